/* hw/rtl/mcl_pkg.sv */
package mcl_pkg;

   // input item kinds, carried in req_tuser
   typedef enum logic [1:0] {
      FUNC_WEIGHT  = 2'd0,
      FUNC_BIAS    = 2'd1,
      FUNC_SAMPLE  = 2'd2,
      FUNC_COMPUTE = 2'd3
   } func_type;

   // result status, carried in rsp_tuser
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_BAD_CFG = 2'd1;
   localparam logic [1:0] STAT_OUTSIDE = 2'd2;

   // configuration register indexes
   localparam logic [2:0] CSR_MAP_WIDTH      = 3'd0;
   localparam logic [2:0] CSR_MAP_HEIGHT     = 3'd1;
   localparam logic [2:0] CSR_KERNEL_SIZE    = 3'd2;
   localparam logic [2:0] CSR_STRIDE         = 3'd3;
   localparam logic [2:0] CSR_PAD            = 3'd4;
   localparam logic [2:0] CSR_INPUT_CHANNELS = 3'd5;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 6;

   localparam int VALUE_W = 16;
   localparam int SUM_W   = 48;

   // req_tdata layout, lowest bit first
   localparam int OC_LSB    = 0;
   localparam int IC_LSB    = 3;
   localparam int ROW_LSB   = 6;
   localparam int COL_LSB   = 11;
   localparam int TR_LSB    = 16;
   localparam int TC_LSB    = 19;
   localparam int VALUE_LSB = 22;
   localparam int REQ_DATA_W = 40;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 48;
   localparam int RSP_USER_W = 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_INIT,
      ST_RUN,
      ST_DRAIN1,
      ST_DRAIN2,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic       setup;     // evaluate status, fetch bias
      logic       init;      // preload accumulator
      logic       issue;     // one tap into the MAC pipeline
      logic       load_out;  // move accumulator into output register
      logic [3:0] tap_c;
      logic [2:0] tap_i;
      logic [2:0] tap_j;
   } ctrl_cmd_type;

   typedef struct packed {
      logic       err;       // status not ok
      logic       skip;      // nothing to accumulate
      logic [3:0] nch;
      logic [2:0] kend;
      logic       out_busy;
   } dp_stat_type;

endpackage

/* hw/rtl/mcl_ctrl.sv */
module mcl_ctrl
   import mcl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  req_tready,
   input  logic                  rsp_tready,
   input  dp_stat_type           stat,
   output ctrl_cmd_type          cmd
);

   state_type  state_ff, state_in;
   logic [3:0] c_ff, c_in;
   logic [2:0] i_ff, i_in;
   logic [2:0] j_ff, j_in;
   logic       last_j, last_i, last_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         c_ff     <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         c_ff     <= c_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
      end
   end

   assign last_j = (j_ff == stat.kend - 3'd1);
   assign last_i = (i_ff == stat.kend - 3'd1);
   assign last_c = (c_ff == stat.nch - 4'd1);

   always_comb begin
      state_in   = state_ff;
      c_in       = c_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.tap_c  = c_ff;
      cmd.tap_i  = i_ff;
      cmd.tap_j  = j_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid && func_type'(req_tuser) == FUNC_COMPUTE) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_INIT;
         end
         ST_INIT: begin
            cmd.init = 1'b1;
            c_in     = '0;
            i_in     = '0;
            j_in     = '0;
            state_in = (stat.err || stat.skip) ? ST_DONE : ST_RUN;
         end
         ST_RUN: begin
            cmd.issue = 1'b1;
            if (!last_j) begin
               j_in = j_ff + 3'd1;
            end else begin
               j_in = '0;
               if (!last_i) begin
                  i_in = i_ff + 3'd1;
               end else begin
                  i_in = '0;
                  c_in = c_ff + 4'd1;
                  if (last_c) begin
                     state_in = ST_DRAIN1;
                  end
               end
            end
         end
         ST_DRAIN1: state_in = ST_DRAIN2;
         ST_DRAIN2: state_in = ST_DONE;
         ST_DONE: begin
            if (!stat.out_busy || rsp_tready) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

/* hw/rtl/mcl_dp.sv */
module mcl_dp
   import mcl_pkg::*;
#(
   parameter int MAX_DIM    = 32,
   parameter int MAX_KERNEL = 5,
   parameter int MAX_IN_CH  = 8,
   parameter int MAX_OUT_CH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [RSP_USER_W-1:0] rsp_tuser,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  ctrl_cmd_type          cmd,
   output dp_stat_type           stat
);

   localparam int KK      = MAX_KERNEL * MAX_KERNEL;
   localparam int W_DEPTH = MAX_OUT_CH * MAX_IN_CH * KK;
   localparam int S_DEPTH = MAX_IN_CH * MAX_DIM * MAX_DIM;
   localparam int W_AW    = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
   localparam int S_AW    = (S_DEPTH > 1) ? $clog2(S_DEPTH) : 1;
   localparam int B_AW    = (MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1;

   // configuration
   logic [5:0] map_width_ff, map_height_ff;
   logic [2:0] kernel_size_ff, pad_ff;
   logic [3:0] stride_ff, input_channels_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff      <= 6'd32;
         map_height_ff     <= 6'd32;
         kernel_size_ff    <= 3'd3;
         stride_ff         <= 4'd1;
         pad_ff            <= 3'd1;
         input_channels_ff <= 4'd1;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MAP_WIDTH:      map_width_ff      <= csr_data;
            CSR_MAP_HEIGHT:     map_height_ff     <= csr_data;
            CSR_KERNEL_SIZE:    kernel_size_ff    <= csr_data[2:0];
            CSR_STRIDE:         stride_ff         <= csr_data[3:0];
            CSR_PAD:            pad_ff            <= csr_data[2:0];
            CSR_INPUT_CHANNELS: input_channels_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // request fields
   logic               req_xfer;
   func_type           func;
   logic [2:0]         f_oc, f_ic, f_tr, f_tc;
   logic [4:0]         f_row, f_col;
   logic [VALUE_W-1:0] f_value;

   assign req_xfer = req_tvalid && req_tready;
   assign func     = func_type'(req_tuser);
   assign f_oc     = req_tdata[OC_LSB +: 3];
   assign f_ic     = req_tdata[IC_LSB +: 3];
   assign f_row    = req_tdata[ROW_LSB +: 5];
   assign f_col    = req_tdata[COL_LSB +: 5];
   assign f_tr     = req_tdata[TR_LSB +: 3];
   assign f_tc     = req_tdata[TC_LSB +: 3];
   assign f_value  = req_tdata[VALUE_LSB +: VALUE_W];

   // write addresses and range checks
   logic [31:0] w_wr_idx, s_wr_idx, b_wr_idx;
   logic        w_wr_ok, s_wr_ok, b_wr_ok;

   assign w_wr_idx = (32'(f_oc) * MAX_IN_CH + 32'(f_ic)) * KK
                     + 32'(f_tr) * MAX_KERNEL + 32'(f_tc);
   assign s_wr_idx = (32'(f_ic) * MAX_DIM + 32'(f_row)) * MAX_DIM + 32'(f_col);
   assign b_wr_idx = 32'(f_oc);
   assign w_wr_ok  = req_xfer && func == FUNC_WEIGHT && 32'(f_oc) < MAX_OUT_CH
                     && 32'(f_ic) < MAX_IN_CH && 32'(f_tr) < MAX_KERNEL
                     && 32'(f_tc) < MAX_KERNEL;
   assign b_wr_ok  = req_xfer && func == FUNC_BIAS && 32'(f_oc) < MAX_OUT_CH;
   assign s_wr_ok  = req_xfer && func == FUNC_SAMPLE && 32'(f_ic) < MAX_IN_CH
                     && 32'(f_row) < MAX_DIM && 32'(f_col) < MAX_DIM;

   // captured compute request
   logic [2:0] oc_ff;
   logic [4:0] row_ff, col_ff;

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         oc_ff  <= f_oc;
         row_ff <= f_row;
         col_ff <= f_col;
      end
   end

   // status and window origin
   logic [8:0]         row_st, col_st;
   logic [1:0]         half_k;
   logic signed [4:0]  pd;
   logic signed [11:0] lim_h, lim_w, y0, x0;
   logic               bad_cfg, outside, oc_ok;
   logic [3:0]         nch;
   logic [2:0]         kend;
   logic [31:0]        b_rd_idx;

   assign row_st  = row_ff * stride_ff;
   assign col_st  = col_ff * stride_ff;
   assign half_k  = kernel_size_ff[2:1];
   assign pd      = $signed({3'b0, half_k}) - $signed({2'b0, pad_ff});
   assign bad_cfg = pd < 0 || stride_ff == 4'd0;
   // row >= ceil(n/stride) is the same as row*stride >= n
   assign lim_h   = $signed({6'b0, map_height_ff}) - ($signed({{7{pd[4]}}, pd}) <<< 1);
   assign lim_w   = $signed({6'b0, map_width_ff}) - ($signed({{7{pd[4]}}, pd}) <<< 1);
   assign outside = $signed({3'b0, row_st}) >= lim_h || $signed({3'b0, col_st}) >= lim_w;
   assign y0      = $signed({3'b0, row_st}) - $signed({9'b0, pad_ff});
   assign x0      = $signed({3'b0, col_st}) - $signed({9'b0, pad_ff});
   assign oc_ok   = 32'(oc_ff) < MAX_OUT_CH;
   assign nch     = (32'(input_channels_ff) < MAX_IN_CH) ? input_channels_ff
                                                          : 4'(MAX_IN_CH);
   assign kend    = (32'(kernel_size_ff) < MAX_KERNEL) ? kernel_size_ff
                                                       : 3'(MAX_KERNEL);
   assign b_rd_idx = 32'(oc_ff);

   logic [1:0]         status_ff;
   logic signed [11:0] y0_ff, x0_ff;
   logic [3:0]         nch_ff;
   logic [2:0]         kend_ff;
   logic               skip_ff, oc_ok_ff;

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         status_ff <= bad_cfg ? STAT_BAD_CFG : (outside ? STAT_OUTSIDE : STAT_OK);
         y0_ff     <= y0;
         x0_ff     <= x0;
         nch_ff    <= nch;
         kend_ff   <= kend;
         skip_ff   <= nch == 4'd0 || kend == 3'd0 || !oc_ok;
         oc_ok_ff  <= oc_ok;
      end
   end

   // tap addresses
   logic signed [11:0] ty, tx;
   logic               tap_ok;
   logic [31:0]        w_rd_idx, s_rd_idx;

   assign ty     = y0_ff + $signed({9'b0, cmd.tap_i});
   assign tx     = x0_ff + $signed({9'b0, cmd.tap_j});
   assign tap_ok = ty >= 0 && tx >= 0
                   && ty < $signed({6'b0, map_height_ff}) && tx < $signed({6'b0, map_width_ff})
                   && ty < MAX_DIM && tx < MAX_DIM;
   assign w_rd_idx = (32'(oc_ff) * MAX_IN_CH + 32'(cmd.tap_c)) * KK
                     + 32'(cmd.tap_i) * MAX_KERNEL + 32'(cmd.tap_j);
   assign s_rd_idx = (32'(cmd.tap_c) * MAX_DIM + 32'($unsigned(ty))) * MAX_DIM
                     + 32'($unsigned(tx));

   // memories
   logic [VALUE_W-1:0]        w_mem [W_DEPTH];
   logic [VALUE_W-1:0]        s_mem [S_DEPTH];
   logic [VALUE_W-1:0]        b_mem [MAX_OUT_CH];
   logic signed [VALUE_W-1:0] w_rd_ff, s_rd_ff, b_rd_ff;

   always_ff @(posedge clock) begin
      if (w_wr_ok) begin
         w_mem[w_wr_idx[W_AW-1:0]] <= f_value;
      end
      w_rd_ff <= w_mem[w_rd_idx[W_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (s_wr_ok) begin
         s_mem[s_wr_idx[S_AW-1:0]] <= f_value;
      end
      s_rd_ff <= s_mem[s_rd_idx[S_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (b_wr_ok) begin
         b_mem[b_wr_idx[B_AW-1:0]] <= f_value;
      end
      b_rd_ff <= b_mem[b_rd_idx[B_AW-1:0]];
   end

   // MAC pipeline: memory read, multiply, accumulate
   logic               v1_ff, ok1_ff, v2_ff;
   logic signed [31:0] prod_ff;
   logic signed [47:0] acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      ok1_ff  <= tap_ok;
      prod_ff <= ok1_ff ? w_rd_ff * s_rd_ff : 32'sd0;
      if (cmd.init) begin
         acc_ff <= (status_ff == STAT_OK && oc_ok_ff)
                   ? $signed({{24{b_rd_ff[15]}}, b_rd_ff, 8'b0}) : 48'sd0;
      end else if (v2_ff) begin
         acc_ff <= acc_ff + $signed({{16{prod_ff[31]}}, prod_ff});
      end
   end

   // output register
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_sum_ff;
   logic [RSP_USER_W-1:0] rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_sum_ff    <= acc_ff;
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_sum_ff;
   assign rsp_tuser  = rsp_status_ff;

   assign stat.err      = status_ff != STAT_OK;
   assign stat.skip     = skip_ff;
   assign stat.nch      = nch_ff;
   assign stat.kend     = kend_ff;
   assign stat.out_busy = rsp_valid_ff;

endmodule

/* hw/rtl/multichannel_conv_layer.sv */
// Multichannel 2-D convolution layer with stride and zero padding.
// req_*: one item per transfer. tuser selects the kind: write weight, write bias,
//   write input sample, or compute one output. Writes produce no response.
//   A compute returns one rsp_* transfer: tdata is the 48-bit Q.16 sum (bias
//   plus weighted taps), tuser the status (ok, bad pad or stride, position
//   outside the output map; sum is zero unless ok).
// csr_*: register writes (map width/height, kernel size, stride, pad, input
//   channels), always ready; write only while the block is idle.
// A compute steps from acceptance through setup, init, run, the drain states
//   and done, then loads the result; N = channels x K x K taps (up to 200) run
//   through the single multiply-accumulate that takes one tap per cycle. Init
//   goes straight to done when the status is not ok or there is nothing to
//   sum. Requests are taken only while idle, writes one per cycle.
// The finished result sits in an output register, so the next request is taken
//   while a response waits; a second result waits until the first is taken.
// Reset clears configuration to 32x32 map, 3x3 kernel, stride 1, pad 1, one
//   channel. Weight, bias and sample memories are not cleared and must be
//   written before they are used.
module multichannel_conv_layer
   import mcl_pkg::*;
#(
   parameter int MAX_DIM    = 32,
   parameter int MAX_KERNEL = 5,
   parameter int MAX_IN_CH  = 8,
   parameter int MAX_OUT_CH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // out_chan[2:0] in_chan[5:3] row[10:6] col[15:11] tap_row[18:16]
   // tap_col[21:19] value[37:22], zero fill to 40 bits
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // func[1:0]
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // sum[47:0]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // status[1:0]
   output logic [RSP_USER_W-1:0] rsp_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   assign csr_ready = 1'b1;

   mcl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   mcl_dp #(
      .MAX_DIM    (MAX_DIM),
      .MAX_KERNEL (MAX_KERNEL),
      .MAX_IN_CH  (MAX_IN_CH),
      .MAX_OUT_CH (MAX_OUT_CH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .stat       (stat)
   );

   // an error response never carries a sum
   a_err_zero_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STAT_OK |-> rsp_tdata == '0)
      else $error("error response with nonzero sum");

   // a pending response is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !rsp_tvalid || rsp_tready)
      else $error("result loaded over an untaken response");

   // no request is taken while taps are in flight
   a_busy_no_req: assert property (@(posedge clock) disable iff (reset)
      cmd.issue || cmd.setup || cmd.init |-> !req_tready)
      else $error("request accepted during a compute");

   // a loaded result shows up on the response channel
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_tvalid)
      else $error("loaded result not presented");

endmodule

/* verif/multichannel_conv_layer_tb.sv */
`timescale 1ns / 1ps

module multichannel_conv_layer_tb;
   import mcl_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_ITEMS   = 1150;

   typedef struct packed {
      func_type    func;
      logic [2:0]  oc;
      logic [2:0]  ic;
      logic [4:0]  row;
      logic [4:0]  col;
      logic [2:0]  tr;
      logic [2:0]  tc;
      logic [15:0] value;
   } conv_req_type;

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic [1:0]       status;
   } conv_result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [REQ_USER_W-1:0] req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   multichannel_conv_layer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // layer settings as the block holds them
   int cfg_width = 32, cfg_height = 32, cfg_ksize = 3;
   int cfg_stride = 1, cfg_pad = 1, cfg_chans = 1;

   // predicted memory contents
   logic signed [15:0] wt_mem  [8][8][5][5];
   logic signed [15:0] bias_mem[8];
   logic signed [15:0] pix_mem [8][32][32];

   // what the stimulus has written so far; computes only read these
   bit wt_done  [8][8][5][5];
   bit bias_done[8];
   bit pix_done [8][32][32];

   conv_req_type    req_backlog[$];
   conv_result_type sums_due[$];

   int issued_total = 0, taken_total = 0, computes_issued = 0;
   int phase_items = 0, phase_computes = 0, settings_used = 0;
   int results_seen = 0, ok_seen = 0, bad_seen = 0, outside_seen = 0;
   int errors = 0;

   function automatic int out_extent(int dim, int pd, int st);
      int n;
      n = dim - 2 * pd;
      if (n <= 0) return 0;
      if (st > 1) n = (n + st - 1) / st;
      return n;
   endfunction

   function automatic logic [1:0] conv_status(int row, int col);
      int pd;
      pd = cfg_ksize / 2 - cfg_pad;
      if (pd < 0 || cfg_stride == 0) return STAT_BAD_CFG;
      if (row >= out_extent(cfg_height, pd, cfg_stride) ||
          col >= out_extent(cfg_width, pd, cfg_stride)) return STAT_OUTSIDE;
      return STAT_OK;
   endfunction

   // updates the memories for writes, queues the expected result for computes
   function automatic void convolve_item(conv_req_type it);
      conv_result_type res;
      longint acc;
      int r, pd, nch, kl, y0, x0, y, x;
      case (it.func)
         FUNC_WEIGHT: begin
            if (it.tr < 5 && it.tc < 5) wt_mem[it.oc][it.ic][it.tr][it.tc] = it.value;
         end
         FUNC_BIAS: bias_mem[it.oc] = it.value;
         FUNC_SAMPLE: pix_mem[it.ic][it.row][it.col] = it.value;
         default: begin
            res.status = conv_status(int'(it.row), int'(it.col));
            res.sum = '0;
            if (res.status == STAT_OK) begin
               r   = cfg_ksize / 2;
               pd  = r - cfg_pad;
               nch = (cfg_chans < 8) ? cfg_chans : 8;
               kl  = (cfg_ksize < 5) ? cfg_ksize : 5;
               y0  = pd + int'(it.row) * cfg_stride - r;
               x0  = pd + int'(it.col) * cfg_stride - r;
               acc = longint'(bias_mem[it.oc]) * 256;
               for (int c = 0; c < nch; c++)
                  for (int i = 0; i < kl; i++)
                     for (int j = 0; j < kl; j++) begin
                        y = y0 + i;
                        x = x0 + j;
                        if (y >= 0 && x >= 0 && y < cfg_height && x < cfg_width &&
                            y < 32 && x < 32)
                           acc += longint'(wt_mem[it.oc][c][i][j]) *
                                  longint'(pix_mem[c][y][x]);
                     end
               res.sum = acc[SUM_W-1:0];
            end
            sums_due.push_back(res);
         end
      endcase
   endfunction

   function automatic int gap_len(bit calm);
      int pick;
      if (calm) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   function automatic logic [15:0] rand_value();
      case ($urandom_range(0, 9))
         0: return 16'h7FFF;
         1: return 16'h8000;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // ---------------- driver ----------------
   conv_req_type req_now;
   int  req_gap = 0;
   bit  req_calm = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            convolve_item(req_now);
            taken_total++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (req_backlog.size() > 0) begin
               req_now = req_backlog.pop_front();
               req_tdata  <= {2'b00, req_now.value, req_now.tc, req_now.tr, req_now.col,
                              req_now.row, req_now.ic, req_now.oc};
               req_tuser  <= req_now.func;
               req_tvalid <= 1'b1;
               if ($urandom_range(0, 39) == 0) req_calm = !req_calm;
               req_gap = gap_len(req_calm);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------- monitor ----------------
   conv_result_type sum_exp;
   int  rsp_stall = 0;
   bit  rsp_calm = 1'b0;
   bit  rsp_taken;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall = 0;
      end else begin
         rsp_taken = rsp_tvalid && rsp_tready;
         if (rsp_taken) begin
            results_seen++;
            if (sums_due.size() == 0) begin
               errors++;
               $display("%0t: result with none expected: sum %0d status %0d", $time,
                        $signed(rsp_tdata), rsp_tuser);
            end else begin
               sum_exp = sums_due.pop_front();
               case (sum_exp.status)
                  STAT_OK:      ok_seen++;
                  STAT_BAD_CFG: bad_seen++;
                  default:      outside_seen++;
               endcase
               if (rsp_tdata !== sum_exp.sum) begin
                  errors++;
                  $display("%0t: sum expected %0d actual %0d", $time,
                           $signed(sum_exp.sum), $signed(rsp_tdata));
               end
               if (rsp_tuser !== sum_exp.status) begin
                  errors++;
                  $display("%0t: status expected %0d actual %0d", $time,
                           sum_exp.status, rsp_tuser);
               end
            end
         end
         if (rsp_taken || $urandom_range(0, 15) == 0) begin
            if ($urandom_range(0, 39) == 0) rsp_calm = !rsp_calm;
            if (rsp_stall == 0) rsp_stall = gap_len(rsp_calm);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------- watchdog ----------------
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ---------------- stimulus ----------------
   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, int val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val[CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_MAP_WIDTH:   cfg_width  = val;
         CSR_MAP_HEIGHT:  cfg_height = val;
         CSR_KERNEL_SIZE: cfg_ksize  = val;
         CSR_STRIDE:      cfg_stride = val;
         CSR_PAD:         cfg_pad    = val;
         default:         cfg_chans  = val;
      endcase
   endtask

   task automatic set_config(int w, int h, int k, int s, int p, int c);
      csr_write(CSR_MAP_WIDTH, w);
      csr_write(CSR_MAP_HEIGHT, h);
      csr_write(CSR_KERNEL_SIZE, k);
      csr_write(CSR_STRIDE, s);
      csr_write(CSR_PAD, p);
      csr_write(CSR_INPUT_CHANNELS, c);
      settings_used++;
   endtask

   // block must be drained before the settings change
   task automatic wait_idle();
      while (taken_total != issued_total || sums_due.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic queue_req(func_type f, int oc, int ic, int row, int col, int tr, int tc,
                            logic [15:0] v);
      conv_req_type it;
      it.func  = f;
      it.oc    = oc[2:0];
      it.ic    = ic[2:0];
      it.row   = row[4:0];
      it.col   = col[4:0];
      it.tr    = tr[2:0];
      it.tc    = tc[2:0];
      it.value = v;
      req_backlog.push_back(it);
      issued_total++;
      phase_items++;
      case (f)
         FUNC_WEIGHT: if (tr < 5 && tc < 5) wt_done[oc][ic][tr][tc] = 1'b1;
         FUNC_BIAS:   bias_done[oc] = 1'b1;
         FUNC_SAMPLE: pix_done[ic][row][col] = 1'b1;
         default: begin
            computes_issued++;
            phase_computes++;
         end
      endcase
   endtask

   // writes whatever the compute will read that was never written, then the compute
   task automatic issue_compute(int oc, int row, int col);
      int r, pd, nch, kl, y, x;
      if (!bias_done[oc]) queue_req(FUNC_BIAS, oc, 0, 0, 0, 0, 0, rand_value());
      if (conv_status(row, col) == STAT_OK) begin
         r   = cfg_ksize / 2;
         pd  = r - cfg_pad;
         nch = (cfg_chans < 8) ? cfg_chans : 8;
         kl  = (cfg_ksize < 5) ? cfg_ksize : 5;
         for (int c = 0; c < nch; c++)
            for (int i = 0; i < kl; i++)
               for (int j = 0; j < kl; j++) begin
                  if (!wt_done[oc][c][i][j])
                     queue_req(FUNC_WEIGHT, oc, c, 0, 0, i, j, rand_value());
                  y = pd + row * cfg_stride - r + i;
                  x = pd + col * cfg_stride - r + j;
                  if (y >= 0 && x >= 0 && y < cfg_height && x < cfg_width &&
                      !pix_done[c][y][x])
                     queue_req(FUNC_SAMPLE, 0, c, y, x, 0, 0, rand_value());
               end
      end
      queue_req(FUNC_COMPUTE, oc, $urandom_range(0, 7), row, col, $urandom_range(0, 7),
                $urandom_range(0, 7), rand_value());
   endtask

   task automatic run_phase(int budget);
      int pick, pd, eh, ew, row, col, kl, nch;
      phase_items = 0;
      phase_computes = 0;
      pd  = cfg_ksize / 2 - cfg_pad;
      eh  = (pd >= 0 && cfg_stride > 0) ? out_extent(cfg_height, pd, cfg_stride) : 0;
      ew  = (pd >= 0 && cfg_stride > 0) ? out_extent(cfg_width, pd, cfg_stride) : 0;
      kl  = (cfg_ksize < 5) ? cfg_ksize : 5;
      nch = (cfg_chans < 8) ? cfg_chans : 8;
      while (phase_items < budget || phase_computes < 6) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            if (eh > 0 && ew > 0 && $urandom_range(0, 4) != 0) begin
               row = $urandom_range(0, eh - 1);
               col = $urandom_range(0, ew - 1);
            end else begin
               row = $urandom_range(0, 31);
               col = $urandom_range(0, 31);
            end
            issue_compute($urandom_range(0, 7), row, col);
         end else if (pick < 70) begin
            // mostly inside the map; the rest may land anywhere, also where the map does not reach
            if ($urandom_range(0, 9) < 7)
               queue_req(FUNC_SAMPLE, $urandom_range(0, 7), $urandom_range(0, nch - 1),
                         $urandom_range(0, cfg_height - 1), $urandom_range(0, cfg_width - 1),
                         $urandom_range(0, 7), $urandom_range(0, 7), rand_value());
            else
               queue_req(FUNC_SAMPLE, $urandom_range(0, 7), $urandom_range(0, 7),
                         $urandom_range(0, 31), $urandom_range(0, 31),
                         $urandom_range(0, 7), $urandom_range(0, 7), rand_value());
         end else if (pick < 88) begin
            // taps past the largest kernel have no storage and are dropped
            if ($urandom_range(0, 9) != 0)
               queue_req(FUNC_WEIGHT, $urandom_range(0, 7), $urandom_range(0, nch - 1),
                         $urandom_range(0, 31), $urandom_range(0, 31),
                         $urandom_range(0, kl - 1), $urandom_range(0, kl - 1), rand_value());
            else
               queue_req(FUNC_WEIGHT, $urandom_range(0, 7), $urandom_range(0, 7),
                         $urandom_range(0, 31), $urandom_range(0, 31),
                         $urandom_range(0, 7), $urandom_range(0, 7), rand_value());
         end else begin
            queue_req(FUNC_BIAS, $urandom_range(0, 7), $urandom_range(0, 7),
                      $urandom_range(0, 31), $urandom_range(0, 31),
                      $urandom_range(0, 7), $urandom_range(0, 7), rand_value());
         end
      end
   endtask

   initial begin
      int base, w, h, k, s, p, c;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: value extremes with a 1x1 kernel, ignored tap write
      set_config(32, 32, 1, 1, 0, 1);
      queue_req(FUNC_WEIGHT, 0, 0, 0, 0, 0, 0, 16'h7FFF);
      queue_req(FUNC_WEIGHT, 0, 0, 0, 0, 7, 7, rand_value());
      queue_req(FUNC_WEIGHT, 7, 7, 0, 0, 4, 4, 16'h8000);
      queue_req(FUNC_WEIGHT, 7, 0, 0, 0, 0, 0, 16'h8000);
      queue_req(FUNC_BIAS, 0, 0, 0, 0, 0, 0, 16'h8000);
      queue_req(FUNC_BIAS, 7, 0, 0, 0, 0, 0, 16'h7FFF);
      queue_req(FUNC_SAMPLE, 0, 0, 31, 31, 0, 0, 16'h8000);
      queue_req(FUNC_SAMPLE, 0, 0, 0, 0, 0, 0, 16'h7FFF);
      queue_req(FUNC_SAMPLE, 0, 7, 31, 0, 0, 0, 16'hFFFF);
      issue_compute(0, 31, 31);
      issue_compute(0, 0, 0);
      issue_compute(7, 31, 31);
      issue_compute(0, 0, 31);
      wait_idle();
      // zero stride
      set_config(32, 32, 1, 0, 0, 1);
      issue_compute(3, 5, 5);
      wait_idle();
      // pad wider than half the kernel
      set_config(32, 32, 1, 1, 1, 1);
      issue_compute(0, 0, 0);
      wait_idle();
      // past the output map on each axis
      set_config(32, 32, 3, 1, 0, 1);
      issue_compute(0, 30, 0);
      issue_compute(0, 0, 31);
      wait_idle();

      base = issued_total;
      set_config(32, 32, 3, 1, 1, 1);  run_phase(100); wait_idle();
      set_config(1, 1, 1, 1, 0, 8);    run_phase(100); wait_idle();
      set_config(32, 2, 5, 8, 2, 2);   run_phase(100); wait_idle();
      set_config(5, 32, 5, 2, 0, 3);   run_phase(100); wait_idle();
      set_config(4, 4, 3, 0, 1, 1);    run_phase(60);  wait_idle();
      set_config(6, 6, 1, 1, 5, 1);    run_phase(60);  wait_idle();
      set_config(3, 3, 5, 1, 0, 1);    run_phase(60);  wait_idle();
      set_config(8, 8, 4, 3, 2, 8);    run_phase(100); wait_idle();
      while (issued_total - base < RANDOM_ITEMS) begin
         w = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32) : $urandom_range(1, 10);
         h = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32) : $urandom_range(1, 10);
         k = $urandom_range(1, 5);
         if ($urandom_range(0, 15) == 0) s = 0;
         else if ($urandom_range(0, 3) == 0) s = $urandom_range(1, 8);
         else s = $urandom_range(1, 2);
         p = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 5) : $urandom_range(0, k / 2);
         c = $urandom_range(1, 8);
         set_config(w, h, k, s, p, c);
         run_phase(100);
         wait_idle();
      end

      repeat (250) @(posedge clock);
      if (sums_due.size() != 0) begin
         errors += sums_due.size();
         $display("%0t: %0d results never arrived", $time, sums_due.size());
      end
      $display("Ran %0d requests (%0d computes) across %0d layer settings.",
               issued_total, computes_issued, settings_used);
      $display("Checked %0d results: %0d ok, %0d bad pad/stride, %0d outside map.",
               results_seen, ok_seen, bad_seen, outside_seen);
      if (errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
